// ===== hdl/stsc_pkg.sv =====
// ----------------------------------------------------------------------------
// stsc_pkg
// Types, constants and character class functions of the script token scanner.
// ----------------------------------------------------------------------------
package stsc_pkg;

	localparam int MaxText       = 4096;
	localparam int MaxTokenCount = 1024;
	localparam int WordLimit     = 32;
	localparam int QueueDepth    = 4;
	localparam int MaxResults    = 2;

	localparam logic [11:0] PosSat     = 12'((MaxText - 1) < 4095 ? (MaxText - 1) : 4095);
	localparam logic [10:0] LimitCap   = 11'(MaxTokenCount < 1024 ? MaxTokenCount : 1024);
	localparam logic [10:0] LimitReset = 11'd1024;

	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChOpen  = 8'h28;
	localparam logic [7:0] ChClose = 8'h29;
	localparam logic [7:0] ChDot   = 8'h2e;
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChCr    = 8'h0d;
	localparam logic [7:0] ChLf    = 8'h0a;

	typedef enum logic [3:0] {
		KIND_EOF     = 4'd0,
		KIND_OPEN    = 4'd1,
		KIND_CLOSE   = 4'd2,
		KIND_WORD    = 4'd3,
		KIND_S32     = 4'd4,
		KIND_U32     = 4'd5,
		KIND_FLOAT   = 4'd6,
		KIND_DOUBLE  = 4'd7,
		KIND_STRING  = 4'd8,
		KIND_UNKNOWN = 4'd9,
		KIND_END     = 4'd10
	} kind_t;

	typedef enum logic [5:0] {
		MODE_START = 6'b000001,
		MODE_IDLE  = 6'b000010,
		MODE_WORD  = 6'b000100,
		MODE_NUM   = 6'b001000,
		MODE_STR   = 6'b010000,
		MODE_DRAIN = 6'b100000
	} mode_t;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_F     = 2'd1,
		CLS_U     = 2'd2
	} cls_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] start;
		logic [11:0] len;
		logic [10:0] num;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r1;
		result_t    r0;
	} push_t;

	function automatic logic [11:0] sat_inc(input logic [11:0] v);
		return (v >= PosSat) ? PosSat : v + 12'd1;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == 8'h5f;
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return c == 8'h2d || c == 8'h2b;
	endfunction

	function automatic cls_t char_class(input logic [7:0] c);
		cls_t r;
		case (c)
			8'h66, 8'h46: r = CLS_F;
			8'h75, 8'h55: r = CLS_U;
			default:      r = CLS_OTHER;
		endcase
		return r;
	endfunction

	function automatic logic is_num_char(input logic [7:0] c);
		return is_digit(c) || is_sign(c) || c == ChDot || c == 8'h65 ||
			char_class(c) != CLS_OTHER;
	endfunction

endpackage

// ===== hdl/script_token_scanner.sv =====
// ----------------------------------------------------------------------------
// script_token_scanner
// Streaming tokenizer for script text. One text byte is taken per cycle
// while text_stall is low; a byte of zero ends the text. Each byte yields
// zero, one or two tokens, which pass through a four-entry result queue and
// leave one per cycle while token_stall is low. A byte enters an input
// register and is classified there; its tokens enter the queue as the byte
// leaves it. The input stalls while the queue holds more than two
// tokens, so a run of bytes that each yield two tokens settles to one token
// per cycle, which is the output rate. The user must write token_limit only
// while no transaction is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module script_token_scanner import stsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        token_limit_we,
	input  logic [10:0] token_limit,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [3:0]  token_kind,
	output logic [11:0] start_offset,
	output logic [11:0] token_length,
	output logic [10:0] token_number,
	output logic        run_last
);

	logic [10:0] limit_q;
	logic        valid_s1;
	logic [7:0]  text_s1;
	logic        step;
	logic        pop;
	push_t       push;
	result_t     head;
	logic [$clog2(QueueDepth):0] fifo_cnt;

	assign step       = valid_s1 && (fifo_cnt <= ($clog2(QueueDepth) + 1)'(QueueDepth - MaxResults));
	assign text_stall = valid_s1 && !step;
	assign pop        = token_valid && !token_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LimitReset;
		end else if (token_limit_we) begin
			limit_q <= token_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			text_s1 <= text_byte;
		end
	end

	stsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.c      (text_s1),
		.limit  (limit_q),
		.push   (push)
	);

	stsc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.cnt    (fifo_cnt)
	);

	assign token_valid  = fifo_cnt != '0;
	assign token_kind   = head.kind;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign token_number = head.num;
	assign run_last     = head.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt <= ($clog2(QueueDepth) + 1)'(QueueDepth))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> fifo_cnt <= ($clog2(QueueDepth) + 1)'(QueueDepth - MaxResults))
		else $error("push without room");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> valid_s1 && fifo_cnt > ($clog2(QueueDepth) + 1)'(QueueDepth - MaxResults))
		else $error("input stalled without a full queue");

	a_eof_fields: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == KIND_EOF |-> token_number == '0 && start_offset == '0)
		else $error("eof token not at index zero");

endmodule

// ===== hdl/stsc_core.sv =====
// ----------------------------------------------------------------------------
// stsc_core
// Scan state and per-byte classification; yields up to two results per byte.
// ----------------------------------------------------------------------------
module stsc_core import stsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  c,
	input  logic [10:0] limit,
	output push_t       push
);

	mode_t       mode_q, mode_v;
	logic [11:0] pos_q, pos_v;
	logic [11:0] pstart_q, pstart_v;
	logic [11:0] plen_q, plen_v;
	logic        dot_q, dot_v;
	cls_t        cls_q, cls_v;
	logic [10:0] tok_q, tok_v;
	logic [10:0] lim;
	logic [1:0]  n_v;
	logic        consumed;
	logic        e_req;
	kind_t       e_kind;
	logic [11:0] e_start;
	logic [11:0] e_len;
	result_t     res_v [MaxResults];

	assign lim = (limit > LimitCap) ? LimitCap : limit;

	always_comb begin
		mode_v   = mode_q;
		pos_v    = pos_q;
		pstart_v = pstart_q;
		plen_v   = plen_q;
		dot_v    = dot_q;
		cls_v    = cls_q;
		tok_v    = tok_q;
		n_v      = 2'd0;
		consumed = 1'b0;
		res_v[0] = '0;
		res_v[1] = '0;

		// start of text: clear and emit eof
		if (mode_v == MODE_START) begin
			pos_v    = '0;
			pstart_v = '0;
			plen_v   = '0;
			dot_v    = 1'b0;
			cls_v    = CLS_OTHER;
			res_v[0] = '{KIND_EOF, 12'd0, 12'd0, 11'd0, 1'b0};
			n_v      = 2'd1;
			tok_v    = 11'd1;
			mode_v   = (tok_v >= lim) ? MODE_DRAIN : MODE_IDLE;
		end

		// pending token
		e_req   = 1'b0;
		e_kind  = KIND_WORD;
		e_start = pstart_v;
		e_len   = plen_v;
		case (mode_v)
			MODE_WORD: begin
				if (is_word_char(c)) begin
					plen_v   = sat_inc(plen_v);
					e_len    = plen_v;
					e_req    = plen_v > 12'(WordLimit);
					consumed = 1'b1;
				end else begin
					e_req = 1'b1;
				end
			end
			MODE_NUM: begin
				if (is_num_char(c)) begin
					plen_v   = sat_inc(plen_v);
					dot_v    = dot_v | (c == ChDot);
					cls_v    = char_class(c);
					consumed = 1'b1;
				end else begin
					e_req = 1'b1;
					if (dot_v) begin
						e_kind = (cls_v == CLS_F) ? KIND_FLOAT : KIND_DOUBLE;
					end else begin
						e_kind = (cls_v == CLS_U) ? KIND_U32 : KIND_S32;
					end
				end
			end
			MODE_STR: begin
				e_kind = KIND_STRING;
				if (c == ChQuote) begin
					plen_v   = sat_inc(plen_v);
					e_len    = plen_v;
					e_req    = 1'b1;
					consumed = 1'b1;
				end else if (c == ChNul || c == ChCr || c == ChLf) begin
					e_req = 1'b1;
				end else begin
					plen_v   = sat_inc(plen_v);
					consumed = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (e_req) begin
			res_v[n_v[0]] = '{e_kind, e_start, e_len, tok_v, 1'b0};
			n_v    = n_v + 2'd1;
			tok_v  = tok_v + 11'd1;
			mode_v = (tok_v >= lim) ? MODE_DRAIN : MODE_IDLE;
		end

		// byte not taken by a pending token
		e_req   = 1'b0;
		e_kind  = KIND_UNKNOWN;
		e_start = pos_v;
		e_len   = 12'd1;
		if (!consumed) begin
			if (c == ChNul) begin
				res_v[n_v[0]] = '{KIND_END, pos_v, 12'd0, tok_v, 1'b0};
				n_v    = n_v + 2'd1;
				mode_v = MODE_START;
			end else if (mode_v == MODE_IDLE) begin
				if (c == ChOpen) begin
					e_req  = 1'b1;
					e_kind = KIND_OPEN;
				end else if (c == ChClose) begin
					e_req  = 1'b1;
					e_kind = KIND_CLOSE;
				end else if (is_space(c)) begin
					e_req = 1'b0;
				end else if (is_alpha(c)) begin
					pstart_v = pos_v;
					plen_v   = 12'd1;
					mode_v   = MODE_WORD;
					e_kind   = KIND_WORD;
					e_req    = 12'd1 > 12'(WordLimit);
				end else if (is_digit(c) || is_sign(c)) begin
					pstart_v = pos_v;
					plen_v   = 12'd1;
					dot_v    = 1'b0;
					cls_v    = CLS_OTHER;
					mode_v   = MODE_NUM;
				end else if (c == ChQuote) begin
					pstart_v = pos_v;
					plen_v   = 12'd1;
					mode_v   = MODE_STR;
				end else begin
					e_req = 1'b1;
				end
			end
		end
		if (e_req) begin
			res_v[n_v[0]] = '{e_kind, e_start, e_len, tok_v, 1'b0};
			n_v    = n_v + 2'd1;
			tok_v  = tok_v + 11'd1;
			mode_v = (tok_v >= lim) ? MODE_DRAIN : MODE_IDLE;
		end

		if (c != ChNul) begin
			pos_v = sat_inc(pos_v);
		end

		// mark the last result of this byte
		if (n_v == 2'd2) begin
			res_v[1].last = 1'b1;
		end else if (n_v == 2'd1) begin
			res_v[0].last = 1'b1;
		end
	end

	assign push.cnt = step ? n_v : 2'd0;
	assign push.r0  = res_v[0];
	assign push.r1  = res_v[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_START;
			pos_q    <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			dot_q    <= 1'b0;
			cls_q    <= CLS_OTHER;
			tok_q    <= '0;
		end else if (step) begin
			mode_q   <= mode_v;
			pos_q    <= pos_v;
			pstart_q <= pstart_v;
			plen_q   <= plen_v;
			dot_q    <= dot_v;
			cls_q    <= cls_v;
			tok_q    <= tok_v;
		end
	end

endmodule

// ===== hdl/stsc_fifo.sv =====
// ----------------------------------------------------------------------------
// stsc_fifo
// Result queue: takes up to two results a cycle, delivers one.
// ----------------------------------------------------------------------------
module stsc_fifo import stsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output result_t head,
	output logic [$clog2(QueueDepth):0] cnt
);

	localparam int PtrW = $clog2(QueueDepth);

	result_t         mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   cnt_q;
	logic [PtrW-1:0] wr_next;

	assign wr_next = wr_ptr_q + PtrW'(1);
	assign head    = mem_q[rd_ptr_q];
	assign cnt     = cnt_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrW'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			cnt_q <= cnt_q + (PtrW + 1)'(push.cnt) - (PtrW + 1)'(pop);
		end
	end

endmodule
